[rtl/core/aes_pkg.sv]
// shared types, codes and substitution tables for the aes block cipher
`timescale 1ns / 1ps

package aes_pkg;

   // register index codes
   localparam logic [2:0] REG_KEY_UPPER = 3'd0;
   localparam logic [2:0] REG_KEY_LOWER = 3'd1;
   localparam logic [2:0] REG_IV_UPPER  = 3'd2;
   localparam logic [2:0] REG_IV_LOWER  = 3'd3;
   localparam logic [2:0] REG_MODE      = 3'd4;

   // cipher modes
   typedef enum logic [1:0] {
      MODE_ECB_ENC = 2'd0,
      MODE_ECB_DEC = 2'd1,
      MODE_CBC_ENC = 2'd2,
      MODE_CBC_DEC = 2'd3
   } mode_type;

   localparam int unsigned ROUNDS = 10;
   localparam int unsigned RK_INDEX_BITS = 4;

   // input and result payloads
   typedef struct packed {
      logic [63:0] block_in_upper;
      logic [63:0] block_in_lower;
      logic        message_end;
   } req_type;

   typedef struct packed {
      logic [63:0] block_out_upper;
      logic [63:0] block_out_lower;
   } rsp_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // round constants by round number
   localparam logic [7:0] RCON [11] = '{
      8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

endpackage

[rtl/core/aes_key_expand.sv]
// iterative aes-128 key schedule and round key store
`timescale 1ns / 1ps

module aes_key_expand (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] key,
   input  logic [aes_pkg::RK_INDEX_BITS-1:0] rk_index,
   output logic [127:0] rk_data,
   output logic         busy
);

   logic [127:0] rk_mem [aes_pkg::ROUNDS+1];
   logic [127:0] prev_ff;
   logic [aes_pkg::RK_INDEX_BITS-1:0] count_ff;
   logic         busy_ff;
   logic [31:0]  temp;
   logic [127:0] next_key;

   // one schedule step: rotate, substitute, add round constant, chain words
   always_comb begin
      temp = {aes_pkg::SBOX[prev_ff[23:16]] ^ aes_pkg::RCON[count_ff],
              aes_pkg::SBOX[prev_ff[15:8]],
              aes_pkg::SBOX[prev_ff[7:0]],
              aes_pkg::SBOX[prev_ff[31:24]]};
      next_key[127:96] = prev_ff[127:96] ^ temp;
      next_key[95:64]  = prev_ff[95:64] ^ next_key[127:96];
      next_key[63:32]  = prev_ff[63:32] ^ next_key[95:64];
      next_key[31:0]   = prev_ff[31:0] ^ next_key[63:32];
   end

   // sequencer, runs after reset and after each key write
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (busy_ff) begin
         if (count_ff == aes_pkg::RK_INDEX_BITS'(aes_pkg::ROUNDS)) busy_ff <= 1'b0;
         count_ff <= count_ff + 1'b1;
      end
   end

   // round key store
   always_ff @(posedge clock) begin
      if (busy_ff && !start && !reset) begin
         if (count_ff == '0) begin
            rk_mem[count_ff] <= key;
            prev_ff          <= key;
         end else begin
            rk_mem[count_ff] <= next_key;
            prev_ff          <= next_key;
         end
      end
   end

   assign rk_data = rk_mem[rk_index];
   assign busy    = busy_ff;

endmodule

[rtl/core/aes_round.sv]
// one aes round, forward or inverse, shared by all rounds of a block
`timescale 1ns / 1ps

module aes_round (
   input  logic [127:0] state_in,
   input  logic [127:0] round_key,
   input  logic         decrypt,
   input  logic         last,
   output logic [127:0] state_out
);

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   logic [7:0] s [16];
   logic [7:0] t [16];
   logic [7:0] u [16];
   logic [7:0] m [16];
   logic [7:0] x2 [16];
   logic [7:0] x4 [16];
   logic [7:0] x8 [16];
   logic [7:0] k [16];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s[i] = state_in[127-8*i -: 8];
         k[i] = round_key[127-8*i -: 8];
      end
      // substitute and shift rows, byte i is row i%4 column i/4
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (decrypt)
               t[r + 4*((c + r) % 4)] = aes_pkg::INV_SBOX[s[r + 4*c]];
            else
               t[r + 4*c] = aes_pkg::SBOX[s[r + 4*((c + r) % 4)]];
         end
      end
      // inverse order adds the key before mixing
      for (int i = 0; i < 16; i++) begin
         u[i]  = decrypt ? (t[i] ^ k[i]) : t[i];
         x2[i] = xtime(u[i]);
         x4[i] = xtime(x2[i]);
         x8[i] = xtime(x4[i]);
      end
      // mix columns
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (decrypt)
               m[4*c + r] = (x8[4*c + r] ^ x4[4*c + r] ^ x2[4*c + r])
                  ^ (x8[4*c + (r+1)%4] ^ x2[4*c + (r+1)%4] ^ u[4*c + (r+1)%4])
                  ^ (x8[4*c + (r+2)%4] ^ x4[4*c + (r+2)%4] ^ u[4*c + (r+2)%4])
                  ^ (x8[4*c + (r+3)%4] ^ u[4*c + (r+3)%4]);
            else
               m[4*c + r] = x2[4*c + r]
                  ^ (x2[4*c + (r+1)%4] ^ u[4*c + (r+1)%4])
                  ^ u[4*c + (r+2)%4] ^ u[4*c + (r+3)%4];
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (decrypt)
            state_out[127-8*i -: 8] = last ? u[i] : m[i];
         else
            state_out[127-8*i -: 8] = (last ? u[i] : m[i]) ^ k[i];
      end
   end

endmodule

[rtl/core/aes128_ecb_cbc_block_cipher.sv]
// aes-128 ecb/cbc engine top level: registers, chaining and round sequencer
//
//   port group   dir   transfer when
//   req_*        in    req_valid & req_ready, one 128-bit block and end flag
//   rsp_*        out   rsp_valid & rsp_ready, one 128-bit block
//   p* (csr)     in    psel & penable & pwrite, 64-bit register write
//
// for a block, the accept cycle adds the first round key, then each round
// passes in turn through the single shared round unit.
// after reset and after each key write the key schedule runs again,
// one round key per cycle, and req_ready stays low until it ends.
// a finished block waits in the round unit while the output register is
// still full; a new block may be accepted while a result waits.
`timescale 1ns / 1ps

module aes128_ecb_cbc_block_cipher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  aes_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output aes_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [5:0]       paddr,
   input  logic [63:0]      pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type         state_ff;
   logic [3:0]        step_ff;
   logic [127:0]      key_ff;
   logic [127:0]      iv_ff;
   aes_pkg::mode_type mode_ff;
   aes_pkg::mode_type run_mode_ff;
   logic [127:0]      chain_ff;
   logic              restart_ff;
   logic [127:0]      block_ff;
   logic [127:0]      prev_ff;
   logic              rsp_valid_ff;
   aes_pkg::rsp_type  rsp_data_ff;

   logic         wr_en;
   logic [2:0]   wr_index;
   logic         key_start;
   logic         key_busy;
   logic [3:0]   rk_index;
   logic [127:0] rk_data;
   logic [127:0] round_out;
   logic         run_decrypt;
   logic         in_decrypt;
   logic [127:0] in_block;
   logic [127:0] prev_in;
   logic         accept;
   logic         out_free;
   logic         rsp_load;
   logic [127:0] result_in;

   // configuration port
   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign wr_index  = paddr[5:3];
   assign key_start = wr_en && (wr_index == aes_pkg::REG_KEY_UPPER ||
                                wr_index == aes_pkg::REG_KEY_LOWER);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         iv_ff   <= '0;
         mode_ff <= aes_pkg::MODE_ECB_ENC;
      end else if (wr_en) begin
         case (wr_index)
            aes_pkg::REG_KEY_UPPER: key_ff[127:64] <= pwdata;
            aes_pkg::REG_KEY_LOWER: key_ff[63:0]   <= pwdata;
            aes_pkg::REG_IV_UPPER:  iv_ff[127:64]  <= pwdata;
            aes_pkg::REG_IV_LOWER:  iv_ff[63:0]    <= pwdata;
            aes_pkg::REG_MODE:      mode_ff <= aes_pkg::mode_type'(pwdata[1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[5:3])
         aes_pkg::REG_KEY_UPPER: prdata = key_ff[127:64];
         aes_pkg::REG_KEY_LOWER: prdata = key_ff[63:0];
         aes_pkg::REG_IV_UPPER:  prdata = iv_ff[127:64];
         aes_pkg::REG_IV_LOWER:  prdata = iv_ff[63:0];
         aes_pkg::REG_MODE:      prdata = {62'd0, mode_ff};
         default:                prdata = '0;
      endcase
   end

   // key schedule
   aes_key_expand u_key (
      .clock    (clock),
      .reset    (reset),
      .start    (key_start),
      .key      (key_ff),
      .rk_index (rk_index),
      .rk_data  (rk_data),
      .busy     (key_busy)
   );

   // round key selection, inverse cipher walks the keys backward
   assign in_decrypt  = (mode_ff == aes_pkg::MODE_ECB_DEC) ||
                        (mode_ff == aes_pkg::MODE_CBC_DEC);
   assign run_decrypt = (run_mode_ff == aes_pkg::MODE_ECB_DEC) ||
                        (run_mode_ff == aes_pkg::MODE_CBC_DEC);
   always_comb begin
      if (state_ff == ST_IDLE)
         rk_index = in_decrypt ? 4'(aes_pkg::ROUNDS) : 4'd0;
      else
         rk_index = run_decrypt ? 4'(aes_pkg::ROUNDS) - step_ff : step_ff;
   end

   aes_round u_round (
      .state_in  (block_ff),
      .round_key (rk_data),
      .decrypt   (run_decrypt),
      .last      (step_ff == 4'(aes_pkg::ROUNDS)),
      .state_out (round_out)
   );

   // input side, cbc encrypt folds the chaining value in first
   assign prev_in  = restart_ff ? iv_ff : chain_ff;
   assign in_block = (mode_ff == aes_pkg::MODE_CBC_ENC)
                   ? {req_data.block_in_upper, req_data.block_in_lower} ^ prev_in
                   : {req_data.block_in_upper, req_data.block_in_lower};
   assign req_ready = (state_ff == ST_IDLE) && !key_busy;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = (state_ff == ST_RUN) && (step_ff == 4'(aes_pkg::ROUNDS)) && out_free;
   assign result_in = (run_mode_ff == aes_pkg::MODE_CBC_DEC) ? round_out ^ prev_ff
                                                             : round_out;

   // round sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 4'd1;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
         restart_ff   <= 1'b1;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  block_ff    <= in_block ^ rk_data;
                  prev_ff     <= prev_in;
                  run_mode_ff <= mode_ff;
                  step_ff     <= 4'd1;
                  state_ff    <= ST_RUN;
                  if (mode_ff == aes_pkg::MODE_CBC_DEC) begin
                     chain_ff   <= {req_data.block_in_upper, req_data.block_in_lower};
                     restart_ff <= req_data.message_end;
                  end else if (mode_ff == aes_pkg::MODE_CBC_ENC) begin
                     restart_ff <= req_data.message_end;
                  end
               end
            end
            ST_RUN: begin
               if (step_ff != 4'(aes_pkg::ROUNDS)) begin
                  block_ff <= round_out;
                  step_ff  <= step_ff + 1'b1;
               end else if (out_free) begin
                  rsp_data_ff  <= {result_in[127:64], result_in[63:0]};
                  if (run_mode_ff == aes_pkg::MODE_CBC_ENC) chain_ff <= round_out;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[bench/tb.sv]
// self-checking bench for the aes-128 ecb/cbc block cipher engine
`timescale 1ns / 1ps

module tb;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   aes_pkg::req_type  req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   aes_pkg::rsp_type  rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [5:0]        paddr;
   logic [63:0]       pwdata;
   logic [63:0]       prdata;
   logic              pready;

   aes128_ecb_cbc_block_cipher u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state and configuration
   logic [127:0]      key_reg;
   logic [127:0]      iv_reg;
   aes_pkg::mode_type mode_reg;
   logic [127:0]      chain_block;
   logic              restart_flag;
   logic [127:0]      round_keys [11];

   aes_pkg::rsp_type  cipher_queue [$];
   int                fail_count;
   int                rsp_count;
   longint            cycle_count;

   function automatic logic [7:0] xtime(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = xtime(a);
      end
      return p;
   endfunction

   // byte k of a block, byte 0 at the top
   function automatic logic [7:0] byte_at(logic [127:0] s, int k);
      return s[127 - 8 * k -: 8];
   endfunction

   function automatic void expand_schedule();
      logic [31:0] w [44];
      logic [31:0] t;
      for (int i = 0; i < 4; i++) w[i] = key_reg[127 - 32 * i -: 32];
      for (int i = 4; i < 44; i++) begin
         t = w[i - 1];
         if (i % 4 == 0)
            t = {aes_pkg::SBOX[t[23:16]] ^ aes_pkg::RCON[i / 4], aes_pkg::SBOX[t[15:8]],
                 aes_pkg::SBOX[t[7:0]], aes_pkg::SBOX[t[31:24]]};
         w[i] = w[i - 4] ^ t;
      end
      for (int r = 0; r < 11; r++)
         round_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
   endfunction

   function automatic logic [127:0] sub_shift_rows(logic [127:0] s, bit inv);
      logic [7:0] t [16];
      logic [127:0] o;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) begin
            if (inv) t[r + 4 * ((c + r) & 3)] = aes_pkg::INV_SBOX[byte_at(s, r + 4 * c)];
            else t[r + 4 * c] = aes_pkg::SBOX[byte_at(s, r + 4 * ((c + r) & 3))];
         end
      for (int k = 0; k < 16; k++) o[127 - 8 * k -: 8] = t[k];
      return o;
   endfunction

   function automatic logic [127:0] mix_cols(logic [127:0] s, bit inv);
      logic [7:0] m [4];
      logic [7:0] col [4];
      logic [7:0] v;
      logic [127:0] o;
      if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
      else m = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) col[k] = byte_at(s, 4 * c + k);
         for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++) v ^= gmul(col[k], m[(k + 4 - r) & 3]);
            o[127 - 8 * (4 * c + r) -: 8] = v;
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] aes_encrypt(logic [127:0] s);
      s ^= round_keys[0];
      for (int r = 1; r < 10; r++) s = mix_cols(sub_shift_rows(s, 0), 0) ^ round_keys[r];
      return sub_shift_rows(s, 0) ^ round_keys[10];
   endfunction

   function automatic logic [127:0] aes_decrypt(logic [127:0] s);
      s ^= round_keys[10];
      for (int r = 9; r > 0; r--) s = mix_cols(sub_shift_rows(s, 1) ^ round_keys[r], 1);
      return sub_shift_rows(s, 1) ^ round_keys[0];
   endfunction

   // expected output for one accepted block, updates chaining
   function automatic aes_pkg::rsp_type predict_block(aes_pkg::req_type item);
      logic [127:0] blk;
      logic [127:0] prev;
      logic [127:0] res;
      blk = {item.block_in_upper, item.block_in_lower};
      prev = restart_flag ? iv_reg : chain_block;
      case (mode_reg)
         aes_pkg::MODE_ECB_ENC: res = aes_encrypt(blk);
         aes_pkg::MODE_ECB_DEC: res = aes_decrypt(blk);
         aes_pkg::MODE_CBC_ENC: begin
            res = aes_encrypt(blk ^ prev);
            chain_block = res;
            restart_flag = item.message_end;
         end
         default: begin
            res = aes_decrypt(blk) ^ prev;
            chain_block = blk;
            restart_flag = item.message_end;
         end
      endcase
      return {res[127:64], res[63:0]};
   endfunction

   // csr write: setup then access phase
   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 3'b000}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         aes_pkg::REG_KEY_UPPER: begin key_reg[127:64] = value; expand_schedule(); end
         aes_pkg::REG_KEY_LOWER: begin key_reg[63:0] = value; expand_schedule(); end
         aes_pkg::REG_IV_UPPER: iv_reg[127:64] = value;
         aes_pkg::REG_IV_LOWER: iv_reg[63:0] = value;
         aes_pkg::REG_MODE: mode_reg = aes_pkg::mode_type'(value[1:0]);
         default: ;
      endcase
   endtask

   // hold the sender until every expected block has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (cipher_queue.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   int burst_left;

   // send one block, with random gaps between bursts
   task automatic send_block(aes_pkg::req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 20);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cipher_queue.push_back(predict_block(item));
      burst_left--;
   endtask

   // receiver stall pattern: alternating open and stalled stretches
   int stall_left;
   bit stalling;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
         stalling <= 1'b0;
      end else if (stall_left == 0) begin
         stalling <= ~stalling;
         stall_left <= stalling ? $urandom_range(5, 60) : $urandom_range(0, 15);
         rsp_ready <= stalling;
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   // result checker
   always @(posedge clock) begin
      aes_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (cipher_queue.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = cipher_queue.pop_front();
            if (rsp_data.block_out_upper !== want.block_out_upper) begin
               $display("%0t upper expected %h actual %h", $time,
                        want.block_out_upper, rsp_data.block_out_upper);
               fail_count++;
            end
            if (rsp_data.block_out_lower !== want.block_out_lower) begin
               $display("%0t lower expected %h actual %h", $time,
                        want.block_out_lower, rsp_data.block_out_lower);
               fail_count++;
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("FAIL aes128_ecb_cbc_block_cipher");
         $finish;
      end
   end

   // directed stimulus table
   typedef struct {
      aes_pkg::mode_type mode;
      aes_pkg::req_type  item;
      bit                known;
      aes_pkg::rsp_type  want;
   } vector_row;

   vector_row vectors [$];

   initial begin
      aes_pkg::req_type item;
      aes_pkg::rsp_type ignored;
      fail_count = 0; rsp_count = 0; cycle_count = 0;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_data = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      key_reg = '0; iv_reg = '0; mode_reg = aes_pkg::MODE_ECB_ENC;
      chain_block = '0; restart_flag = 1'b1;
      expand_schedule();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (15) @(posedge clock);

      // zero key zero block after reset, known aes answer
      vectors.push_back('{aes_pkg::MODE_ECB_ENC, '{64'h0, 64'h0, 1'b0}, 1'b1,
                          '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e}});
      vectors.push_back('{aes_pkg::MODE_ECB_DEC, '{64'h66e94bd4ef8a2c3b,
                          64'h884cfa59ca342b2e, 1'b0}, 1'b1, '{64'h0, 64'h0}});
      vectors.push_back('{aes_pkg::MODE_ECB_ENC, '{'1, '1, 1'b1}, 1'b0, '0});
      vectors.push_back('{aes_pkg::MODE_ECB_DEC, '{'1, '0, 1'b1}, 1'b0, '0});
      vectors.push_back('{aes_pkg::MODE_CBC_ENC, '{'0, '0, 1'b0}, 1'b0, '0});
      vectors.push_back('{aes_pkg::MODE_CBC_ENC, '{'1, '1, 1'b0}, 1'b0, '0});
      vectors.push_back('{aes_pkg::MODE_CBC_ENC, '{64'h0123456789abcdef, '0, 1'b1},
                          1'b0, '0});
      vectors.push_back('{aes_pkg::MODE_CBC_ENC, '{'0, '1, 1'b0}, 1'b0, '0});
      vectors.push_back('{aes_pkg::MODE_CBC_DEC, '{'1, '1, 1'b0}, 1'b0, '0});
      vectors.push_back('{aes_pkg::MODE_CBC_DEC, '{'0, '0, 1'b1}, 1'b0, '0});
      vectors.push_back('{aes_pkg::MODE_CBC_DEC, '{64'hdeadbeef, '1, 1'b0}, 1'b0, '0});

      // directed pass: mode writes happen only while idle
      foreach (vectors[i]) begin
         if (vectors[i].mode != mode_reg) begin
            drain_results();
            csr_write(aes_pkg::REG_MODE, {62'd0, vectors[i].mode});
         end
         // known rows are ecb, so the check call leaves the chaining state alone
         if (vectors[i].known) begin
            ignored = predict_block(vectors[i].item);
            if (ignored !== vectors[i].want) begin
               $display("%0t table row %0d expected %h predictor %h", $time, i,
                        vectors[i].want, ignored);
               fail_count++;
            end
         end
         send_block(vectors[i].item);
      end
      drain_results();

      // extreme keys and iv, then random phases
      csr_write(aes_pkg::REG_KEY_UPPER, '1);
      csr_write(aes_pkg::REG_KEY_LOWER, '1);
      csr_write(aes_pkg::REG_IV_UPPER, '1);
      csr_write(aes_pkg::REG_IV_LOWER, '1);
      for (int phase = 0; phase < 10; phase++) begin
         if (phase > 0) begin
            drain_results();
            csr_write(aes_pkg::REG_KEY_UPPER, {$urandom, $urandom});
            csr_write(aes_pkg::REG_KEY_LOWER, {$urandom, $urandom});
            csr_write(aes_pkg::REG_IV_UPPER, {$urandom, $urandom});
            csr_write(aes_pkg::REG_IV_LOWER, {$urandom, $urandom});
         end
         csr_write(aes_pkg::REG_MODE, {62'd0, 2'(phase % 4)});
         for (int n = 0; n < 50; n++) begin
            item.block_in_upper = {$urandom, $urandom};
            item.block_in_lower = {$urandom, $urandom};
            item.message_end = ($urandom_range(0, 5) == 0);
            send_block(item);
         end
      end
      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && cipher_queue.size() == 0)
         $display("PASS aes128_ecb_cbc_block_cipher");
      else
         $display("FAIL aes128_ecb_cbc_block_cipher");
      $finish;
   end

endmodule
